// File: rtl/core/matrix3_inverse_transpose_defines.svh
// Assertion macros shared by the RTL of the matrix inverse-transpose block.
`ifndef MATRIX3_INVERSE_TRANSPOSE_DEFINES_SVH
`define MATRIX3_INVERSE_TRANSPOSE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define M3IT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define M3IT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/m3it_pkg.sv
package m3it_pkg;

  // Default entry format: signed Q16.16.
  localparam int DEF_ENTRY_WIDTH = 32;
  localparam int DEF_FRAC_BITS   = 16;

  // Configuration port.
  localparam int          ADDR_W              = 3;
  localparam logic        REG_DET_THRESHOLD   = 1'b0;
  localparam logic [31:0] DET_THRESHOLD_RESET = 32'd42950;

  // Cofactor k is MUL_A/B[2k] product minus MUL_A/B[2k+1] product,
  // with entries numbered row * 3 + column.
  localparam int NUM_PRODUCTS = 18;
  localparam int MUL_A [NUM_PRODUCTS] = '{4, 5, 5, 3, 3, 4, 2, 1, 0, 2, 1, 0, 1, 2, 2, 0, 0, 1};
  localparam int MUL_B [NUM_PRODUCTS] = '{8, 7, 6, 8, 7, 6, 7, 8, 8, 6, 6, 7, 5, 4, 3, 5, 4, 3};

endpackage

// File: rtl/core/m3it_div.sv
module m3it_div #(
  parameter int ENTRY_WIDTH = m3it_pkg::DEF_ENTRY_WIDTH,
  parameter int FRAC_BITS   = m3it_pkg::DEF_FRAC_BITS
) (
  input  logic                                   clk,
  input  logic [2*ENTRY_WIDTH+2*FRAC_BITS-1:0]   num,
  input  logic [3*ENTRY_WIDTH+2:0]               den,
  input  logic                                   neg,
  input  logic                                   ovf,
  output logic [ENTRY_WIDTH-1:0]                 res
);
  import m3it_pkg::*;

  localparam int W  = ENTRY_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int NB = 2*W + 2*F;
  localparam int DW = 3*W + 3;
  localparam int XB = ((NB > DW + W) ? NB : DW + W) + 1;

  // Restoring division, one quotient bit per stage, MSB first.
  logic [NB-1:0] rem [W+1];
  logic [W-1:0]  quo [W+1];
  logic [DW-1:0] dd  [W+1];
  logic          sg  [W+1];
  logic          ov  [W+1];
  logic [W-1:0]  ge;
  logic [NB-1:0] rem_next [W];

  // Trial subtract of the divisor shifted to each stage's bit weight.
  always_comb begin
    logic [XB-1:0] dsh;
    logic [XB-1:0] rx;
    for (int s = 0; s < W; s++) begin
      dsh = XB'(dd[s]) << (W - 1 - s);
      rx  = XB'(rem[s]);
      ge[s] = (rx >= dsh);
      rem_next[s] = ge[s] ? NB'(rx - dsh) : rem[s];
    end
  end

  always_ff @(posedge clk) begin
    rem[0] <= num;
    quo[0] <= '0;
    dd[0]  <= den;
    sg[0]  <= neg;
    ov[0]  <= ovf;
    for (int s = 0; s < W; s++) begin
      rem[s+1] <= rem_next[s];
      quo[s+1] <= {quo[s][W-2:0], ge[s]};
      dd[s+1]  <= dd[s];
      sg[s+1]  <= sg[s];
      ov[s+1]  <= ov[s];
    end
  end

  // Round half away from zero on the magnitude, then saturate and apply the sign.
  logic          rnd;
  logic [W:0]    qr;
  logic [W:0]    lim;
  logic [W:0]    mag;
  logic [W-1:0]  res_next;

  always_comb begin
    rnd = ((XB'(rem[W]) << 1) >= XB'(dd[W]));
    qr  = {1'b0, quo[W]} + (W+1)'(rnd);
    lim = (W+1)'(1) << (W - 1);
    if (sg[W]) begin
      mag      = (ov[W] || qr > lim) ? lim : qr;
      res_next = W'((W+1)'(0) - mag);
    end else begin
      mag      = (ov[W] || qr > lim - (W+1)'(1)) ? lim - (W+1)'(1) : qr;
      res_next = W'(mag);
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

// File: rtl/core/matrix3_inverse_transpose.sv
// Transpose of the inverse of a 3x3 signed fixed-point matrix, fully pipelined.
// Throughput: one request per cycle; busy is never raised and results cannot stall.
// The depth is set by the divider, which resolves one quotient bit per stage.
// Reset (synchronous, rst high) clears the valid pipeline and sets det_threshold.
`include "matrix3_inverse_transpose_defines.svh"

module matrix3_inverse_transpose #(
  parameter int ENTRY_WIDTH = m3it_pkg::DEF_ENTRY_WIDTH,
  parameter int FRAC_BITS   = m3it_pkg::DEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [ENTRY_WIDTH-1:0]  a00,
  input  logic signed [ENTRY_WIDTH-1:0]  a01,
  input  logic signed [ENTRY_WIDTH-1:0]  a02,
  input  logic signed [ENTRY_WIDTH-1:0]  a10,
  input  logic signed [ENTRY_WIDTH-1:0]  a11,
  input  logic signed [ENTRY_WIDTH-1:0]  a12,
  input  logic signed [ENTRY_WIDTH-1:0]  a20,
  input  logic signed [ENTRY_WIDTH-1:0]  a21,
  input  logic signed [ENTRY_WIDTH-1:0]  a22,
  output logic                           done,
  output logic                           ok,
  output logic signed [ENTRY_WIDTH-1:0]  r00,
  output logic signed [ENTRY_WIDTH-1:0]  r01,
  output logic signed [ENTRY_WIDTH-1:0]  r02,
  output logic signed [ENTRY_WIDTH-1:0]  r10,
  output logic signed [ENTRY_WIDTH-1:0]  r11,
  output logic signed [ENTRY_WIDTH-1:0]  r12,
  output logic signed [ENTRY_WIDTH-1:0]  r20,
  output logic signed [ENTRY_WIDTH-1:0]  r21,
  output logic signed [ENTRY_WIDTH-1:0]  r22,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [m3it_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import m3it_pkg::*;

  localparam int W       = ENTRY_WIDTH;
  localparam int F       = FRAC_BITS;
  localparam int PW      = 2*W;
  localparam int CW      = 2*W + 1;
  localparam int DW      = 3*W + 3;
  localparam int NB      = 2*W + 2*F;
  localparam int XB      = ((NB > DW + W) ? NB : DW + W) + 1;
  localparam int THW     = (DW > 32 + F) ? DW : 32 + F;
  localparam int DIV_LAT = W + 1;
  localparam int LAT     = W + 10;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // Configuration register.
  logic [31:0] det_threshold;
  logic        cfg_wr;

  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_DET_THRESHOLD);
  assign prdata = (paddr[2] == REG_DET_THRESHOLD) ? det_threshold : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_threshold <= DET_THRESHOLD_RESET;
    end else if (cfg_wr) begin
      det_threshold <= pwdata;
    end
  end

  // Valid bits for the front stages.
  logic [8:1] vp;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else begin
      vp <= {vp[7:1], start && !busy};
    end
  end

  // Stage 1: capture the request.
  logic signed [W-1:0] a_s1 [9];

  always_ff @(posedge clk) begin
    a_s1[0] <= a00;
    a_s1[1] <= a01;
    a_s1[2] <= a02;
    a_s1[3] <= a10;
    a_s1[4] <= a11;
    a_s1[5] <= a12;
    a_s1[6] <= a20;
    a_s1[7] <= a21;
    a_s1[8] <= a22;
  end

  // Stage 2: the eighteen 2x2 minor products.
  logic signed [PW-1:0] pr_s2 [NUM_PRODUCTS];
  logic signed [W-1:0]  a_s2  [3];

  always_ff @(posedge clk) begin
    for (int g = 0; g < NUM_PRODUCTS; g++) begin
      pr_s2[g] <= a_s1[MUL_A[g]] * a_s1[MUL_B[g]];
    end
    for (int j = 0; j < 3; j++) begin
      a_s2[j] <= a_s1[j];
    end
  end

  // Stage 3: cofactors.
  logic signed [CW-1:0] c_s3 [9];
  logic signed [W-1:0]  a_s3 [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      c_s3[k] <= CW'(pr_s2[2*k]) - CW'(pr_s2[2*k+1]);
    end
    for (int j = 0; j < 3; j++) begin
      a_s3[j] <= a_s2[j];
    end
  end

  // Stage 4: determinant partial products on split cofactors; cofactor magnitudes.
  logic signed [PW:0]   pl_s4 [3];
  logic signed [PW:0]   ph_s4 [3];
  logic [PW-1:0]        cmag_s4 [9];
  logic                 cneg_s4 [9];

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      pl_s4[j] <= a_s3[j] * $signed({1'b0, c_s3[j][W-1:0]});
      ph_s4[j] <= a_s3[j] * $signed(c_s3[j][CW-1:W]);
    end
    for (int k = 0; k < 9; k++) begin
      cneg_s4[k] <= c_s3[k][CW-1];
      cmag_s4[k] <= c_s3[k][CW-1] ? PW'(-c_s3[k]) : PW'(c_s3[k]);
    end
  end

  // Stage 5: recombine each row term.
  logic signed [DW-1:0] t_s5 [3];
  logic [PW-1:0]        cmag_s5 [9];
  logic                 cneg_s5 [9];

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      t_s5[j] <= (DW'(ph_s4[j]) <<< W) + DW'(pl_s4[j]);
    end
    cmag_s5 <= cmag_s4;
    cneg_s5 <= cneg_s4;
  end

  // Stage 6: exact determinant.
  logic signed [DW-1:0] det_s6;
  logic [PW-1:0]        cmag_s6 [9];
  logic                 cneg_s6 [9];

  always_ff @(posedge clk) begin
    det_s6  <= t_s5[0] + t_s5[1] + t_s5[2];
    cmag_s6 <= cmag_s5;
    cneg_s6 <= cneg_s5;
  end

  // Stage 7: determinant magnitude and result signs.
  logic [DW-1:0] dmag_s7;
  logic [PW-1:0] cmag_s7 [9];
  logic          neg_s7  [9];

  always_ff @(posedge clk) begin
    dmag_s7 <= det_s6[DW-1] ? DW'(-det_s6) : DW'(det_s6);
    cmag_s7 <= cmag_s6;
    for (int k = 0; k < 9; k++) begin
      neg_s7[k] <= cneg_s6[k] ^ det_s6[DW-1];
    end
  end

  // Stage 8: threshold test; divider operands and quotient overflow check.
  logic          ok_s8;
  logic [NB-1:0] num_c [9];
  logic          ovf_c [9];

  always_ff @(posedge clk) begin
    ok_s8 <= (dmag_s7 != '0) && (THW'(dmag_s7) >= (THW'(det_threshold) << F));
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      num_c[k] = NB'(cmag_s7[k]) << (2*F);
      ovf_c[k] = (XB'(cmag_s7[k]) << (2*F)) >= (XB'(dmag_s7) << W);
    end
  end

  // Nine divider lanes share the determinant.
  logic [W-1:0] res [9];

  for (genvar k = 0; k < 9; k++) begin : g_lane
    m3it_div #(
      .ENTRY_WIDTH (ENTRY_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
    ) u_div (
      .clk (clk),
      .num (num_c[k]),
      .den (dmag_s7),
      .neg (neg_s7[k]),
      .ovf (ovf_c[k]),
      .res (res[k])
    );
  end

  // Valid and success flag follow the divider.
  logic [DIV_LAT:1] vd;
  logic [DIV_LAT:1] okd;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= '0;
    end else begin
      vd <= {vd[DIV_LAT-1:1], vp[8]};
    end
    okd <= {okd[DIV_LAT-1:1], ok_s8};
  end

  // Output register; a rejected matrix gives all zeros.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vd[DIV_LAT];
    end
    ok  <= okd[DIV_LAT];
    r00 <= okd[DIV_LAT] ? res[0] : '0;
    r01 <= okd[DIV_LAT] ? res[1] : '0;
    r02 <= okd[DIV_LAT] ? res[2] : '0;
    r10 <= okd[DIV_LAT] ? res[3] : '0;
    r11 <= okd[DIV_LAT] ? res[4] : '0;
    r12 <= okd[DIV_LAT] ? res[5] : '0;
    r20 <= okd[DIV_LAT] ? res[6] : '0;
    r21 <= okd[DIV_LAT] ? res[7] : '0;
    r22 <= okd[DIV_LAT] ? res[8] : '0;
  end

  // A result appears only for an earlier accepted request.
  `M3IT_ASSERT_IMP(a_done_latency, done, $past(start && !busy, LAT), "result without request")
  // A singular matrix never passes the threshold test.
  `M3IT_ASSERT_NXT(a_zero_det_rejected, vp[7] && dmag_s7 == '0, !ok_s8, "zero det accepted")
  // A rejected result carries zero entries on the diagonal.
  `M3IT_ASSERT_IMP(a_reject_zero, done && !ok, r00 == '0 && r11 == '0 && r22 == '0, "nonzero on reject")

endmodule
